[rtl/char_display_shadow_writer_core_assert.svh]
// Assertion macros for the character display shadow writer.
// Expects signals named clock and reset in the scope of each use.
`ifndef CHAR_DISPLAY_SHADOW_WRITER_CORE_ASSERT_SVH
`define CHAR_DISPLAY_SHADOW_WRITER_CORE_ASSERT_SVH

// same-cycle implication
`define CDSW_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cdsw: implication check failed");

// next-cycle implication
`define CDSW_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cdsw: next-cycle check failed");

`endif

[rtl/cdsw_pkg.sv]
// Shared types and constants of the character display shadow writer.
// No dependencies.
package cdsw_pkg;

   localparam int ROW_W  = 3;
   localparam int COL_W  = 5;
   localparam int BYTE_W = 8;
   localparam int BASE_W = 7;

   localparam logic [7:0] CMD_SET_ADDR   = 8'h80;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TILDE     = 8'h7E;
   localparam logic [7:0] CHAR_BLOCK     = 8'hFF;
   localparam logic [7:0] SHADOW_INVALID = 8'h01;

   localparam logic [6:0] BASE0_RESET = 7'd0;
   localparam logic [6:0] BASE1_RESET = 7'd32;
   localparam logic [6:0] BASE2_RESET = 7'd64;
   localparam logic [6:0] BASE3_RESET = 7'd96;

   typedef enum logic [1:0] {
      MODE_GOTO  = 2'd0,
      MODE_CHAR  = 2'd1,
      MODE_CMD   = 2'd2,
      MODE_INVAL = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SEND0,
      ST_SEND1
   } state_type;

   typedef struct packed {
      logic accept;
      logic eval;
      logic load0;
      logic load1;
   } cmd_type;

   typedef struct packed {
      logic [1:0] eval_count;
      logic       pend_two;
      logic       out_free;
   } status_type;

endpackage

[rtl/cdsw_ram.sv]
// Generic single-port-write, registered-read RAM.
// No dependencies.
module cdsw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 80
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/cdsw_ctrl.sv]
// Sequencer of the shadow writer: accept, evaluate, then up to two bus writes.
// Depends on cdsw_pkg.
module cdsw_ctrl import cdsw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = (status.eval_count == 2'd0) ? ST_IDLE : ST_SEND0;
         end
         ST_SEND0: begin
            if (status.out_free) begin
               cmd.load0 = 1'b1;
               state_in  = status.pend_two ? ST_SEND1 : ST_IDLE;
            end
         end
         ST_SEND1: begin
            if (status.out_free) begin
               cmd.load1 = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[rtl/cdsw_datapath.sv]
// Datapath: row bases, cursors, shadow store, result buffer and output register.
// Depends on cdsw_pkg, cdsw_ram and the assertion macro header.
`include "char_display_shadow_writer_core_assert.svh"
module cdsw_datapath import cdsw_pkg::*; #(
   parameter int ROWS = 4,
   parameter int COLS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [1:0]        req_mode,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [COL_W-1:0]  req_col,
   input  logic [BYTE_W-1:0] req_byte_value,
   input  logic              csr_write,
   input  logic [1:0]        csr_index,
   input  logic [BASE_W-1:0] csr_wdata,
   output logic [BASE_W-1:0] csr_rdata,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_data,
   output logic [BYTE_W-1:0] rsp_payload,
   output logic              rsp_last
);

   localparam int CELLS = ROWS * COLS;
   localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;

   function automatic logic [7:0] addr_cmd(input logic [BASE_W-1:0] base,
                                           input logic [COL_W-1:0] c);
      return CMD_SET_ADDR | ({1'b0, base} + {3'b000, c});
   endfunction

   // row bases
   logic [BASE_W-1:0] base_ff [4];
   logic [BASE_W-1:0] base_in [4];

   // latched item
   logic [1:0]        mode_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [BYTE_W-1:0] byte_ff;

   // cursors
   logic             lok_ff, lok_in, hok_ff, hok_in;
   logic [ROW_W-1:0] lrow_ff, lrow_in, hrow_ff, hrow_in;
   logic [COL_W-1:0] lcol_ff, lcol_in, hcol_ff, hcol_in;

   // shadow valid bits; an invalid cell reads as SHADOW_INVALID
   logic [CELLS-1:0] valid_ff, valid_in;

   // pending results and output register
   logic              pend0_is_data_ff, pend0_last_ff, pend_two_ff;
   logic [BYTE_W-1:0] pend0_payload_ff, pend1_payload_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_is_data_ff, rsp_last_ff;
   logic [BYTE_W-1:0] rsp_payload_ff;

   // evaluation
   logic [IDX_W-1:0]  idx;
   logic [BYTE_W-1:0] ram_rdata, cell_val, byte_clean, r0_payload;
   logic              cur_ok, hit, need_addr, wrap, goto_ok, r0_is_data;
   logic              shadow_we, valid_clr, out_free;
   logic [1:0]        n_res;
   logic [ROW_W-1:0]  lrow_adv;
   logic [COL_W-1:0]  lcol_adv;

   always_comb begin
      base_in = base_ff;
      if (csr_write) begin
         base_in[csr_index] = csr_wdata;
      end
   end

   assign csr_rdata = base_ff[csr_index];

   assign idx = IDX_W'(int'(lrow_ff) * COLS + int'(lcol_ff));

   cdsw_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (CELLS)
   ) u_shadow (
      .clock (clock),
      .we    (shadow_we),
      .waddr (idx),
      .wdata (byte_clean),
      .raddr (idx),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (byte_ff != CHAR_BLOCK && (byte_ff < CHAR_SPACE || byte_ff > CHAR_TILDE)) begin
         byte_clean = CHAR_SPACE;
      end else begin
         byte_clean = byte_ff;
      end
   end

   assign cur_ok    = lok_ff && (int'(lrow_ff) < ROWS) && (int'(lcol_ff) < COLS);
   assign cell_val  = valid_ff[idx] ? ram_rdata : SHADOW_INVALID;
   assign hit       = (cell_val == byte_clean);
   assign need_addr = !hok_ff || (hrow_ff != lrow_ff) || (hcol_ff != lcol_ff);
   assign wrap      = (int'(lcol_ff) + 1) >= COLS;
   assign lcol_adv  = wrap ? '0 : lcol_ff + COL_W'(1);
   assign lrow_adv  = wrap ? lrow_ff + ROW_W'(1) : lrow_ff;
   assign goto_ok   = (int'(row_ff) < ROWS) && (int'(col_ff) < COLS);

   always_comb begin
      n_res      = 2'd0;
      r0_is_data = 1'b0;
      r0_payload = byte_clean;
      shadow_we  = 1'b0;
      valid_clr  = 1'b0;
      lok_in     = lok_ff;
      lrow_in    = lrow_ff;
      lcol_in    = lcol_ff;
      hok_in     = hok_ff;
      hrow_in    = hrow_ff;
      hcol_in    = hcol_ff;
      if (cmd.eval) begin
         unique case (mode_type'(mode_ff))
            MODE_GOTO: begin
               if (goto_ok) begin
                  n_res      = 2'd1;
                  r0_payload = addr_cmd(base_ff[row_ff[1:0]], col_ff);
                  lok_in     = 1'b1;
                  lrow_in    = row_ff;
                  lcol_in    = col_ff;
                  hok_in     = 1'b1;
                  hrow_in    = row_ff;
                  hcol_in    = col_ff;
               end
            end
            MODE_CHAR: begin
               if (!cur_ok) begin
                  // no usable cursor: data byte alone, state untouched
                  n_res      = 2'd1;
                  r0_is_data = 1'b1;
               end else if (hit) begin
                  lrow_in = lrow_adv;
                  lcol_in = lcol_adv;
               end else begin
                  shadow_we = 1'b1;
                  lrow_in   = lrow_adv;
                  lcol_in   = lcol_adv;
                  if (wrap) begin
                     hok_in  = 1'b0;
                     hrow_in = '0;
                     hcol_in = '0;
                  end else begin
                     hok_in  = 1'b1;
                     hrow_in = lrow_adv;
                     hcol_in = lcol_adv;
                  end
                  if (need_addr) begin
                     n_res      = 2'd2;
                     r0_payload = addr_cmd(base_ff[lrow_ff[1:0]], lcol_ff);
                  end else begin
                     n_res      = 2'd1;
                     r0_is_data = 1'b1;
                  end
               end
            end
            MODE_CMD: begin
               n_res      = 2'd1;
               r0_payload = byte_ff;
               lok_in     = 1'b0;
               lrow_in    = '0;
               lcol_in    = '0;
               hok_in     = 1'b0;
               hrow_in    = '0;
               hcol_in    = '0;
            end
            MODE_INVAL: begin
               valid_clr = 1'b1;
               lok_in    = 1'b0;
               lrow_in   = '0;
               lcol_in   = '0;
               hok_in    = 1'b0;
               hrow_in   = '0;
               hcol_in   = '0;
            end
            default: n_res = 2'd0;
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (valid_clr) begin
         valid_in = '0;
      end else if (shadow_we) begin
         valid_in[idx] = 1'b1;
      end
   end

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (cmd.load0 || cmd.load1) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff[0]   <= BASE0_RESET;
         base_ff[1]   <= BASE1_RESET;
         base_ff[2]   <= BASE2_RESET;
         base_ff[3]   <= BASE3_RESET;
         lok_ff       <= 1'b0;
         lrow_ff      <= '0;
         lcol_ff      <= '0;
         hok_ff       <= 1'b0;
         hrow_ff      <= '0;
         hcol_ff      <= '0;
         valid_ff     <= '0;
         pend_two_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         lok_ff       <= lok_in;
         lrow_ff      <= lrow_in;
         lcol_ff      <= lcol_in;
         hok_ff       <= hok_in;
         hrow_ff      <= hrow_in;
         hcol_ff      <= hcol_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cmd.eval) begin
            pend_two_ff <= (n_res == 2'd2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff <= req_mode;
         row_ff  <= req_row;
         col_ff  <= req_col;
         byte_ff <= req_byte_value;
      end
      if (cmd.eval) begin
         pend0_is_data_ff <= r0_is_data;
         pend0_payload_ff <= r0_payload;
         pend0_last_ff    <= (n_res == 2'd1);
         pend1_payload_ff <= byte_clean;
      end
      if (cmd.load0) begin
         rsp_is_data_ff <= pend0_is_data_ff;
         rsp_payload_ff <= pend0_payload_ff;
         rsp_last_ff    <= pend0_last_ff;
      end else if (cmd.load1) begin
         rsp_is_data_ff <= 1'b1;
         rsp_payload_ff <= pend1_payload_ff;
         rsp_last_ff    <= 1'b1;
      end
   end

   assign status.eval_count = n_res;
   assign status.pend_two   = pend_two_ff;
   assign status.out_free   = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_is_data = rsp_is_data_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_last    = rsp_last_ff;

   `CDSW_ASSERT_IMP(a_load_needs_room, cmd.load0 || cmd.load1, out_free)
   `CDSW_ASSERT_IMP(a_second_needs_two, cmd.load1, pend_two_ff)
   `CDSW_ASSERT_NXT(a_load_shows_item, cmd.load0 || cmd.load1, rsp_valid_ff)
   `CDSW_ASSERT_IMP(a_cursor_in_bounds, lok_ff, int'(lrow_ff) <= ROWS)

endmodule

[rtl/char_display_shadow_writer_core.sv]
// Top level of the character display shadow writer: APB register port,
// sequencer and datapath. Depends on cdsw_pkg, cdsw_ctrl and cdsw_datapath.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  mode, row, col, byte_value
//   rsp       out        rsp_valid / rsp_stall  is_data, payload, last
//   csr       in         psel/penable/pready    paddr (index at [3:2]), pwdata
//
// An item is accepted and evaluated (shadow read), then sends up to two bus
// writes (set-address then data). While the output register is free, the
// sequencer moves one bus write per cycle into the single output register.
// A stalled result holds the sequencer until the output register frees; the
// next item is taken while the last result of the previous one still waits.
// Reset is synchronous; it clears the cursors and shadow valid bits and sets
// the row bases to their reset values at once, so no clearing pass is needed.
module char_display_shadow_writer_core import cdsw_pkg::*; #(
   parameter int ROWS = 4,
   parameter int COLS = 20
) (
   input  logic              clock,
   input  logic              reset,
   // item in
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_mode,
   input  logic [ROW_W-1:0]  req_row,
   input  logic [COL_W-1:0]  req_col,
   input  logic [BYTE_W-1:0] req_byte_value,
   // bus write out
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_is_data,
   output logic [BYTE_W-1:0] rsp_payload,
   output logic              rsp_last,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cmd_type           cmd;
   status_type        status;
   logic              csr_write;
   logic [BASE_W-1:0] csr_rdata;

   // zero-wait-state port; write lands on the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = {{(32 - BASE_W){1'b0}}, csr_rdata};

   cdsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cdsw_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_byte_value (req_byte_value),
      .csr_write      (csr_write),
      .csr_index      (paddr[3:2]),
      .csr_wdata      (pwdata[BASE_W-1:0]),
      .csr_rdata      (csr_rdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_data    (rsp_is_data),
      .rsp_payload    (rsp_payload),
      .rsp_last       (rsp_last)
   );

endmodule
